### rtl/core/dfc_pkg.sv
// Shared types and constants for the delimited frame checker.
`default_nettype none

package dfc_pkg;

    localparam int BYTE_W       = 8;
    localparam int CFG_ADDR_W   = 2;
    localparam int ACCOUNT_W    = 48;
    localparam int LEN_OUT_W    = 11;
    localparam int META_SIZE_W  = 7;
    localparam int DECL_W       = 14;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_HEAD  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPLIT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TAIL  = 2'd2;

    localparam logic [BYTE_W-1:0] HEAD_RESET  = 8'd3;
    localparam logic [BYTE_W-1:0] SPLIT_RESET = 8'd5;
    localparam logic [BYTE_W-1:0] TAIL_RESET  = 8'd2;

    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

    // Metadata layout: two size digits, event at 3, account 4..9, length digits from 10
    localparam int META_DIGITS    = 2;
    localparam int EVENT_OFFSET   = 3;
    localparam int ACCOUNT_OFFSET = 4;
    localparam int ACCOUNT_BYTES  = 6;
    localparam int LENGTH_OFFSET  = 10;

    localparam logic [2:0]        DELIM_SAT = 3'd7;
    localparam logic [2:0]        DELIM_OK  = 3'd3;
    localparam logic [DECL_W-1:0] DECL_SAT  = 14'd16383;

    typedef enum logic [2:0] {
        VERDICT_OK            = 3'd0,
        VERDICT_DELIM_COUNT   = 3'd1,
        VERDICT_META_DIGIT    = 3'd2,
        VERDICT_META_LENGTH   = 3'd3,
        VERDICT_META_SHORT    = 3'd4,
        VERDICT_LENGTH_DIGIT  = 3'd5,
        VERDICT_PAYLOAD_LEN   = 3'd6
    } verdict_t;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              buffer_end;
    } dfc_in_t;

    typedef struct packed {
        verdict_t             verdict;
        logic [BYTE_W-1:0]    event_byte;
        logic [ACCOUNT_W-1:0] account_bytes;
        logic [LEN_OUT_W-1:0] payload_length;
    } dfc_out_t;

    typedef struct packed {
        logic [BYTE_W-1:0] head;
        logic [BYTE_W-1:0] split;
        logic [BYTE_W-1:0] tail;
    } dfc_delims_t;

endpackage

`default_nettype wire

### rtl/core/dfc_cfg_regs.sv
// Delimiter configuration registers with plain write port.
`default_nettype none

module dfc_cfg_regs
    import dfc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [BYTE_W-1:0]     cfg_wdata,
    output dfc_delims_t                delims
);

    dfc_delims_t delims_reg;
    dfc_delims_t delims_next;

    always_comb begin
        delims_next = delims_reg;
        if (cfg_we) begin
            case (cfg_addr)
                CFG_HEAD:  delims_next.head  = cfg_wdata;
                CFG_SPLIT: delims_next.split = cfg_wdata;
                CFG_TAIL:  delims_next.tail  = cfg_wdata;
                default:   delims_next       = delims_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delims_reg.head  <= HEAD_RESET;
            delims_reg.split <= SPLIT_RESET;
            delims_reg.tail  <= TAIL_RESET;
        end else begin
            delims_reg <= delims_next;
        end
    end

    assign delims = delims_reg;

endmodule

`default_nettype wire

### rtl/core/dfc_frame_track.sv
// Per-frame state: delimiter and section counters, digit accumulators, verdict logic.
`default_nettype none

module dfc_frame_track
    import dfc_pkg::*;
#(
    parameter int PAYLOAD_MAX = 2047,
    parameter int META_MAX    = 99
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step,
    input  wire dfc_in_t     item,
    input  wire dfc_delims_t delims,
    output dfc_out_t         result
);

    localparam int MC_W  = $clog2(META_MAX + 2);
    localparam int DC_W  = $clog2(PAYLOAD_MAX + 2);
    localparam int CMP_W = (DC_W > DECL_W) ? DC_W : DECL_W;

    logic [2:0]             delim_cnt_reg,  delim_cnt_next;
    logic [MC_W-1:0]        meta_cnt_reg,   meta_cnt_next;
    logic [DC_W-1:0]        data_cnt_reg,   data_cnt_next;
    logic [META_SIZE_W-1:0] meta_size_reg,  meta_size_next;
    logic [DECL_W-1:0]      decl_size_reg,  decl_size_next;
    logic [1:0]             dig_err_reg,    dig_err_next;
    logic [BYTE_W-1:0]      event_reg,      event_next;
    logic [ACCOUNT_W-1:0]   account_reg,    account_next;

    logic               is_delim;
    logic               is_digit;
    logic [3:0]         digit_val;
    logic [10:0]        meta_size_mul;
    logic [DECL_W+3:0]  decl_mul;
    logic [DC_W-1:0]    len_sat;
    verdict_t           verdict;

    assign is_delim  = (item.in_byte == delims.head) || (item.in_byte == delims.split)
                       || (item.in_byte == delims.tail);
    assign is_digit  = item.in_byte inside {[ASCII_ZERO:ASCII_NINE]};
    assign digit_val = item.in_byte[3:0];

    // times ten as shift-and-add, then add the digit
    assign meta_size_mul = {1'b0, meta_size_reg, 3'b000} + {3'b000, meta_size_reg, 1'b0}
                           + {7'd0, digit_val};
    assign decl_mul      = {1'b0, decl_size_reg, 3'b000} + {3'b000, decl_size_reg, 1'b0}
                           + {14'd0, digit_val};

    always_comb begin
        delim_cnt_next = delim_cnt_reg;
        meta_cnt_next  = meta_cnt_reg;
        data_cnt_next  = data_cnt_reg;
        meta_size_next = meta_size_reg;
        decl_size_next = decl_size_reg;
        dig_err_next   = dig_err_reg;
        event_next     = event_reg;
        account_next   = account_reg;

        if (is_delim) begin
            if (delim_cnt_reg != DELIM_SAT) begin
                delim_cnt_next = delim_cnt_reg + 3'd1;
            end
        end else if (delim_cnt_reg == 3'd1) begin
            if (meta_cnt_reg < MC_W'(META_DIGITS)) begin
                if (is_digit) begin
                    meta_size_next = meta_size_mul[META_SIZE_W-1:0];
                end else begin
                    dig_err_next[0] = 1'b1;
                end
            end else if (meta_cnt_reg == MC_W'(EVENT_OFFSET)) begin
                event_next = item.in_byte;
            end else if (meta_cnt_reg >= MC_W'(ACCOUNT_OFFSET)
                         && meta_cnt_reg < MC_W'(ACCOUNT_OFFSET + ACCOUNT_BYTES)) begin
                account_next = {account_reg[ACCOUNT_W-BYTE_W-1:0], item.in_byte};
            end else if (meta_cnt_reg >= MC_W'(LENGTH_OFFSET)) begin
                if (is_digit) begin
                    decl_size_next = (decl_mul > (DECL_W+4)'(DECL_SAT)) ? DECL_SAT
                                     : decl_mul[DECL_W-1:0];
                end else begin
                    dig_err_next[1] = 1'b1;
                end
            end
            if (meta_cnt_reg < MC_W'(META_MAX + 1)) begin
                meta_cnt_next = meta_cnt_reg + MC_W'(1);
            end
        end else if (delim_cnt_reg == 3'd2) begin
            if (data_cnt_reg < DC_W'(PAYLOAD_MAX + 1)) begin
                data_cnt_next = data_cnt_reg + DC_W'(1);
            end
        end
    end

    // Verdict from the state that includes the current byte; first failing check wins
    always_comb begin
        if (delim_cnt_next != DELIM_OK) begin
            verdict = VERDICT_DELIM_COUNT;
        end else if (meta_cnt_next < MC_W'(META_DIGITS) || dig_err_next[0]) begin
            verdict = VERDICT_META_DIGIT;
        end else if (meta_cnt_next > MC_W'(META_MAX)
                     || 8'(meta_size_next) != 8'(meta_cnt_next)) begin
            verdict = VERDICT_META_LENGTH;
        end else if (meta_cnt_next <= MC_W'(LENGTH_OFFSET)) begin
            verdict = VERDICT_META_SHORT;
        end else if (dig_err_next[1]) begin
            verdict = VERDICT_LENGTH_DIGIT;
        end else if (data_cnt_next > DC_W'(PAYLOAD_MAX)
                     || CMP_W'(decl_size_next) != CMP_W'(data_cnt_next)) begin
            verdict = VERDICT_PAYLOAD_LEN;
        end else begin
            verdict = VERDICT_OK;
        end
    end

    assign len_sat = (data_cnt_next > DC_W'(PAYLOAD_MAX)) ? DC_W'(PAYLOAD_MAX) : data_cnt_next;

    assign result = '{verdict:        verdict,
                      event_byte:     event_next,
                      account_bytes:  account_next,
                      payload_length: LEN_OUT_W'(len_sat)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_cnt_reg <= '0;
            meta_cnt_reg  <= '0;
            data_cnt_reg  <= '0;
            meta_size_reg <= '0;
            decl_size_reg <= '0;
            dig_err_reg   <= '0;
            event_reg     <= '0;
            account_reg   <= '0;
        end else if (step) begin
            if (item.buffer_end) begin
                delim_cnt_reg <= '0;
                meta_cnt_reg  <= '0;
                data_cnt_reg  <= '0;
                meta_size_reg <= '0;
                decl_size_reg <= '0;
                dig_err_reg   <= '0;
                event_reg     <= '0;
                account_reg   <= '0;
            end else begin
                delim_cnt_reg <= delim_cnt_next;
                meta_cnt_reg  <= meta_cnt_next;
                data_cnt_reg  <= data_cnt_next;
                meta_size_reg <= meta_size_next;
                decl_size_reg <= decl_size_next;
                dig_err_reg   <= dig_err_next;
                event_reg     <= event_next;
                account_reg   <= account_next;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/delimited_frame_checker.sv
// Output: m_valid rises once the buffer's last byte has left the input register and its
// verdict is loaded into the result register, where it waits until m_ready is high.
// Throughput: one byte item per cycle; an input register and a result register each hold
// one item, so bytes keep flowing while a verdict waits and only a last byte waits for it.
// Reset: synchronous, active-low aresetn clears the frame state and both stages and
// reloads the head, split and tail delimiters with 3, 5 and 2.
`default_nettype none

module delimited_frame_checker
    import dfc_pkg::*;
#(
    parameter int PAYLOAD_MAX = 2047,
    parameter int META_MAX    = 99
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [BYTE_W-1:0]     cfg_wdata,
    // byte items in
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire dfc_in_t               s_item,
    // verdict items out
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output dfc_out_t                   m_result
);

    dfc_delims_t delims;

    // Input stage: holds one byte item
    logic     in_valid_reg, in_valid_next;
    dfc_in_t  in_item_reg;

    // Result stage: holds one verdict item
    logic     out_valid_reg, out_valid_next;
    dfc_out_t out_result_reg;

    dfc_out_t frame_result;
    logic     advance;

    dfc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .delims    (delims)
    );

    dfc_frame_track #(
        .PAYLOAD_MAX (PAYLOAD_MAX),
        .META_MAX    (META_MAX)
    ) u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .delims  (delims),
        .result  (frame_result)
    );

    // Advance the held byte unless it closes a frame and the result stage is still full.
    assign advance = in_valid_reg
                     && (!in_item_reg.buffer_end || !out_valid_reg || m_ready);

    // Take a new item whenever the input stage is empty or drains this cycle.
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && in_item_reg.buffer_end) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on handshake, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance && in_item_reg.buffer_end) begin
            out_result_reg <= frame_result;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_result_reg;

endmodule

`default_nettype wire
